### hdl/nst_pkg.sv
// shared types and codes for the named semaphore table
package nst_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned INIT_W = 16;
  localparam int unsigned PID_W  = 5;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_WAIT    = 2'd2,
    REQ_POST    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // controls from sequencer to key search unit
  typedef struct packed {
    logic start;
  } srch_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } srch_sts_t;

endpackage

### hdl/named_semaphore_table.sv
// named semaphore table: items on in_* are create, destroy, wait or post
// requests on a semaphore named by a 64-bit key; each item gives exactly one
// result item on out_*, both channels valid/ready.
// the block takes one item at a time: in_ready is low from acceptance until
// the result has been taken.
// the key search steps one slot per cycle through a single shared
// comparator over the key memory, stopping at the first hit; a miss
// searches all NUM_SLOTS slots. the next item can be accepted at the
// earliest in the cycle after the result is taken.
// a stalled receiver holds the result in the output register and keeps
// in_ready low until it is taken.
// reset (rst_n low, synchronous) empties the table: every slot free, the
// free list in slot order, counts zero and wait stacks empty. no clearing
// pass is needed, the block is ready on the first cycle after reset.
module named_semaphore_table #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned NUM_PROCS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic [nst_pkg::KEY_W-1:0]   in_name_key,
  input  logic [nst_pkg::INIT_W-1:0]  in_init_value,
  input  logic                        in_sem_kind,
  input  logic [nst_pkg::PID_W-1:0]   in_process_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [1:0]                  out_status,
  output logic                        out_caller_blocked,
  output logic                        out_wake_valid,
  output logic [nst_pkg::PID_W-1:0]   out_wake_process
);
  import nst_pkg::*;

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_READ   = 5'b00100,
    S_EXEC   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // request capture
  req_t              req_r;
  logic [KEY_W-1:0]  key_r;
  logic [COUNT_BITS-1:0] init_r;
  logic              kind_r;
  logic [PROC_W-1:0] pid_r;

  // per-slot flags with reset values
  logic [NUM_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [NUM_SLOTS-1:0] wne_r, wne_nxt;
  logic [NUM_SLOTS-1:0] fnv_r, fnv_nxt;
  logic [NUM_SLOTS-1:0] cnt_wr_r, cnt_wr_nxt;   // count entry written since reset
  logic [NUM_SLOTS-1:0] fn_wr_r, fn_wr_nxt;     // free_next entry written
  logic [SLOT_W-1:0]    ftop_r, ftop_nxt;
  logic                 fne_r, fne_nxt;

  // memories
  logic [KEY_W-1:0]      key_mem  [NUM_SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem  [NUM_SLOTS];
  logic                  gen_mem  [NUM_SLOTS];
  logic [PROC_W-1:0]     wtop_mem [NUM_SLOTS];
  logic [SLOT_W-1:0]     fn_mem   [NUM_SLOTS];
  logic [PROC_W-1:0]     link_mem [NUM_PROCS];
  logic                  lv_mem   [NUM_PROCS];

  logic [KEY_W-1:0]      rd_key;
  logic [SLOT_W-1:0]     srch_idx;
  logic [SLOT_W-1:0]     hit_idx;
  srch_ctl_t             sctl;
  srch_sts_t             ssts;

  // operand reads for the chosen slot
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  gen_q;
  logic [PROC_W-1:0]     wtop_q;
  logic [SLOT_W-1:0]     fn_q;
  logic [PROC_W-1:0]     link_q;
  logic                  lv_q;

  // output register
  logic                  ov_r, ov_nxt;
  logic                  ok_r, ok_nxt;
  status_t               st_r, st_nxt;
  logic                  blk_r, blk_nxt;
  logic                  wv_r, wv_nxt;
  logic [PID_W-1:0]      wp_r, wp_nxt;

  // write strobes
  logic                  key_we, cnt_we, gen_we, wtop_we, fn_we, link_we;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [PROC_W-1:0]     wtop_wd;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [SLOT_W-1:0]     fn_eff;

  logic                  accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // process ids wrap at NUM_PROCS through a fixed lookup
  function automatic logic [PROC_W-1:0] pid_wrap(input logic [PID_W-1:0] p);
    logic [PROC_W-1:0] w;
    w = '0;
    for (int i = 0; i < (1 << PID_W); i++) begin
      if (p == PID_W'(i)) begin
        w = PROC_W'(i % NUM_PROCS);
      end
    end
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= req_t'(in_req_type);
      key_r  <= in_name_key;
      kind_r <= in_sem_kind;
      pid_r  <= pid_wrap(in_process_id);
      if (INIT_W > COUNT_BITS && (in_init_value >> COUNT_BITS) != '0) begin
        init_r <= CNT_MAX;
      end else begin
        init_r <= COUNT_BITS'(in_init_value);
      end
    end
  end

  // key memory read address is the search unit's next index
  always_ff @(posedge clk) begin
    rd_key <= key_mem[srch_idx];
  end

  assign sctl.start = accept;

  nst_search #(.NUM_SLOTS(NUM_SLOTS), .SLOT_W(SLOT_W)) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sctl),
    .key     (key_r),
    .in_use  (in_use_r),
    .rd_idx  (srch_idx),
    .rd_key  (rd_key),
    .sts     (ssts),
    .hit_idx (hit_idx)
  );

  // registered operand reads
  always_ff @(posedge clk) begin
    cnt_q  <= cnt_mem[slot_nxt];
    gen_q  <= gen_mem[slot_nxt];
    wtop_q <= wtop_mem[slot_nxt];
    fn_q   <= fn_mem[slot_nxt];
  end
  // wait stack top is known in S_READ, its link arrives for S_EXEC
  always_ff @(posedge clk) begin
    link_q <= link_mem[wtop_q];
    lv_q   <= lv_mem[wtop_q];
  end

  assign cnt_eff = cnt_wr_r[slot_r] ? cnt_q : '0;
  assign fn_eff  = fn_wr_r[slot_r] ? fn_q :
                   ((slot_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_r + 1'b1);

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    in_use_nxt = in_use_r;
    wne_nxt    = wne_r;
    fnv_nxt    = fnv_r;
    cnt_wr_nxt = cnt_wr_r;
    fn_wr_nxt  = fn_wr_r;
    ftop_nxt   = ftop_r;
    fne_nxt    = fne_r;
    ov_nxt     = ov_r;
    ok_nxt     = ok_r;
    st_nxt     = st_r;
    blk_nxt    = blk_r;
    wv_nxt     = wv_r;
    wp_nxt     = wp_r;
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    gen_we     = 1'b0;
    wtop_we    = 1'b0;
    fn_we      = 1'b0;
    link_we    = 1'b0;
    cnt_wd     = cnt_eff;
    wtop_wd    = pid_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (ssts.done) begin
          slot_nxt  = ssts.found ? hit_idx : ftop_r;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // the slot's operands are already read; the wait stack link arrives for S_EXEC
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ok_nxt  = 1'b0;
        st_nxt  = ST_DONE;
        blk_nxt = 1'b0;
        wv_nxt  = 1'b0;
        wp_nxt  = '0;
        if (req_r == REQ_CREATE) begin
          if (ssts.found) begin
            st_nxt = ST_EXISTS;
          end else if (!fne_r) begin
            st_nxt = ST_FULL;
          end else begin
            in_use_nxt[slot_r] = 1'b1;
            wne_nxt[slot_r]    = 1'b0;
            key_we             = 1'b1;
            gen_we             = 1'b1;
            cnt_we             = 1'b1;
            cnt_wd             = init_r;
            fne_nxt            = fnv_r[slot_r];
            ftop_nxt           = fn_eff;
            ok_nxt             = 1'b1;
          end
        end else if (!ssts.found) begin
          st_nxt = ST_NOT_FOUND;
        end else if (req_r == REQ_DESTROY) begin
          in_use_nxt[slot_r] = 1'b0;
          wne_nxt[slot_r]    = 1'b0;
          fn_we              = 1'b1;
          fnv_nxt[slot_r]    = fne_r;
          ftop_nxt           = slot_r;
          fne_nxt            = 1'b1;
          ok_nxt             = 1'b1;
        end else if (req_r == REQ_WAIT) begin
          if (cnt_eff != '0) begin
            cnt_we = 1'b1;
            cnt_wd = cnt_eff - 1'b1;
          end else begin
            link_we         = 1'b1;
            wtop_we         = 1'b1;
            wtop_wd         = pid_r;
            wne_nxt[slot_r] = 1'b1;
            blk_nxt         = 1'b1;
          end
          ok_nxt = 1'b1;
        end else begin
          if (cnt_eff != '0) begin
            if (gen_q && cnt_eff != CNT_MAX) begin
              cnt_we = 1'b1;
              cnt_wd = cnt_eff + 1'b1;
            end
          end else if (wne_r[slot_r]) begin
            wv_nxt          = 1'b1;
            wp_nxt          = PID_W'(wtop_q);
            wtop_we         = 1'b1;
            wtop_wd         = link_q;
            wne_nxt[slot_r] = lv_q;
          end else if (cnt_eff != CNT_MAX) begin
            cnt_we = 1'b1;
            cnt_wd = cnt_eff + 1'b1;
          end
          ok_nxt = 1'b1;
        end
        if (cnt_we) begin
          cnt_wr_nxt[slot_r] = 1'b1;
        end
        if (fn_we) begin
          fn_wr_nxt[slot_r] = 1'b1;
        end
        ov_nxt    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          ov_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_use_r <= '0;
      wne_r    <= '0;
      fnv_r    <= {1'b0, {(NUM_SLOTS-1){1'b1}}};
      cnt_wr_r <= '0;
      fn_wr_r  <= '0;
      ftop_r   <= '0;
      fne_r    <= 1'b1;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      wne_r    <= wne_nxt;
      fnv_r    <= fnv_nxt;
      cnt_wr_r <= cnt_wr_nxt;
      fn_wr_r  <= fn_wr_nxt;
      ftop_r   <= ftop_nxt;
      fne_r    <= fne_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    ok_r   <= ok_nxt;
    st_r   <= st_nxt;
    blk_r  <= blk_nxt;
    wv_r   <= wv_nxt;
    wp_r   <= wp_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[slot_r] <= key_r;
    end
    if (gen_we) begin
      gen_mem[slot_r] <= kind_r;
    end
    if (cnt_we) begin
      cnt_mem[slot_r] <= cnt_wd;
    end
    if (wtop_we) begin
      wtop_mem[slot_r] <= wtop_wd;
    end
    if (fn_we) begin
      fn_mem[slot_r] <= ftop_r;
    end
    if (link_we) begin
      link_mem[pid_r] <= wtop_q;
      lv_mem[pid_r]   <= wne_r[slot_r];
    end
  end

  assign out_valid          = ov_r;
  assign out_ok             = ok_r;
  assign out_status         = st_r;
  assign out_caller_blocked = blk_r;
  assign out_wake_valid     = wv_r;
  assign out_wake_process   = wp_r;

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok == (out_status == ST_DONE)))
    else $error("ok and status disagree");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_caller_blocked && out_wake_valid))
    else $error("blocked and wake together");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !fne_r |-> (in_use_r == '1))
    else $error("free list empty with a free slot");
`endif

endmodule

### hdl/nst_search.sv
// key search unit: one shared 64-bit comparator stepping over the slots
module nst_search #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned SLOT_W    = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nst_pkg::srch_ctl_t       ctl,
  input  logic [nst_pkg::KEY_W-1:0] key,
  input  logic [NUM_SLOTS-1:0]     in_use,
  output logic [SLOT_W-1:0]        rd_idx,
  input  logic [nst_pkg::KEY_W-1:0] rd_key,
  output nst_pkg::srch_sts_t       sts,
  output logic [SLOT_W-1:0]        hit_idx
);
  import nst_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] hit_r, hit_nxt;
  logic              match;
  logic              last;

  // the key store is read at idx_nxt through a register, so rd_key belongs to idx_r
  assign rd_idx = idx_nxt;
  assign match  = in_use[idx_r] && (rd_key == key);
  assign last   = (idx_r == SLOT_W'(NUM_SLOTS - 1));

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      found_nxt = 1'b0;
      idx_nxt   = '0;
    end else if (busy_r) begin
      // lowest matching slot wins, so stop at the first hit
      if (match) begin
        found_nxt = 1'b1;
        hit_nxt   = idx_r;
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
      end else if (last) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign sts.found = found_r;
  assign hit_idx   = hit_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("search started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("search done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without search");
`endif

endmodule
